// File: rtl/bpac_pkg.sv
// Shared types and constants for the two-button auto-repeat and combo core.
package bpac_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_RPT_DELAY    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RPT_START    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RPT_MIN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_RPT_SHRINK   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COMBO_HOLD   = 3'd5;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd25;
    localparam logic [CFG_W-1:0] RST_RPT_DELAY    = 16'd350;
    localparam logic [CFG_W-1:0] RST_RPT_START    = 16'd160;
    localparam logic [CFG_W-1:0] RST_RPT_MIN      = 16'd35;
    localparam logic [CFG_W-1:0] RST_RPT_SHRINK   = 16'd18;
    localparam logic [CFG_W-1:0] RST_COMBO_HOLD   = 16'd1000;

    localparam logic signed [1:0] STEP_LEFT  = -2'sd1;
    localparam logic signed [1:0] STEP_RIGHT = 2'sd1;
    localparam logic signed [1:0] STEP_NONE  = 2'sd0;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] rpt_delay;
        logic [CFG_W-1:0] rpt_start;
        logic [CFG_W-1:0] rpt_min;
        logic [CFG_W-1:0] rpt_shrink;
        logic [CFG_W-1:0] combo_hold;
    } t_cfg;

endpackage

// File: rtl/bpac_in_if.sv
// Input channel: one millisecond tick with time and raw button levels.
interface bpac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_time;
    logic        left_level;
    logic        right_level;

    modport source (output valid, output now_time, output left_level, output right_level,
                    input ready);
    modport sink   (input valid, input now_time, input left_level, input right_level,
                    output ready);
endinterface

// File: rtl/bpac_out_if.sv
// Output channel: step, menu pulse and debounced button states per tick.
interface bpac_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] step_delta;
    logic              menu_pulse;
    logic              left_pressed;
    logic              right_pressed;

    modport source (output valid, output step_delta, output menu_pulse,
                    output left_pressed, output right_pressed, input ready);
    modport sink   (input valid, input step_delta, input menu_pulse,
                    input left_pressed, input right_pressed, output ready);
endinterface

// File: rtl/bpac_button.sv
// One button: debounce, fresh-press step and accelerating auto-repeat.
module bpac_button import bpac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_raw,
    input  logic              i_both,
    input  t_cfg              i_cfg,
    output logic              o_pressed,
    output logic              o_step
);

    logic              r_stable;
    logic              r_last;
    logic [TIME_W-1:0] r_change;
    logic [TIME_W-1:0] r_nft;
    logic [CFG_W-1:0]  r_iv;
    logic              r_fresh;

    logic              n_stable;
    logic [TIME_W-1:0] n_change;
    logic [TIME_W-1:0] n_nft;
    logic [CFG_W-1:0]  n_iv;
    logic              n_fresh;

    logic [TIME_W-1:0] settle_age;
    logic [TIME_W-1:0] due_diff;
    logic [CFG_W:0]    floor_sum;
    logic [CFG_W-1:0]  rpt_iv;
    logic              accept;
    logic              press;
    logic              step;

    always_comb begin
        n_change   = (i_raw != r_last) ? i_now : r_change;
        settle_age = i_now - n_change;
        accept     = (settle_age >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce})
                     && (i_raw != r_stable);
        n_stable   = accept ? i_raw : r_stable;
        press      = accept && !i_raw;
    end

    always_comb begin
        floor_sum  = {1'b0, i_cfg.rpt_min} + {1'b0, i_cfg.rpt_shrink};
        rpt_iv     = ({1'b0, r_iv} > floor_sum) ? (r_iv - i_cfg.rpt_shrink) : i_cfg.rpt_min;
        due_diff   = i_now - r_nft;

        n_fresh = press ? 1'b1 : r_fresh;
        n_nft   = press ? (i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.rpt_delay}) : r_nft;
        n_iv    = press ? i_cfg.rpt_start : r_iv;
        step    = 1'b0;

        if (n_stable || i_both) begin
            n_fresh = 1'b0;
        end else if (n_fresh) begin
            n_fresh = 1'b0;
            step    = 1'b1;
        end else if (!due_diff[TIME_W-1]) begin
            // no press this tick here, so the held interval and fire time apply
            step  = 1'b1;
            n_iv  = rpt_iv;
            n_nft = i_now + {{(TIME_W-CFG_W){1'b0}}, rpt_iv};
        end
    end

    assign o_pressed = !n_stable;
    assign o_step    = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_last   <= 1'b1;
            r_change <= '0;
            r_nft    <= '0;
            r_iv     <= '0;
            r_fresh  <= 1'b0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_last   <= i_raw;
            r_change <= n_change;
            r_nft    <= n_nft;
            r_iv     <= n_iv;
            r_fresh  <= n_fresh;
        end
    end

endmodule

// File: rtl/bpac_combo.sv
// Both-held combo timer: one menu pulse per hold past the threshold.
module bpac_combo import bpac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_both,
    input  logic [CFG_W-1:0]  i_hold,
    output logic              o_menu
);

    logic [TIME_W-1:0] r_start;
    logic              r_active;
    logic              r_done;

    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] held;
    logic              fire;

    always_comb begin
        n_start = r_active ? r_start : i_now;
        held    = i_now - n_start;
        fire    = i_both && !r_done && (held >= {{(TIME_W-CFG_W){1'b0}}, i_hold});
    end

    assign o_menu = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_en) begin
            if (i_both) begin
                r_start  <= n_start;
                r_active <= 1'b1;
                r_done   <= r_done || fire;
            end else begin
                r_active <= 1'b0;
                r_done   <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/button_pair_autorepeat_combo_core.sv
// Top level: tick input register, per-button and combo logic, result register.
//
// Each input beat is one millisecond tick; each tick yields exactly one result
// beat. A tick is captured in an input register, evaluated combinationally
// against the button and combo state, and written to the result register
// together with the state update, so one tick per clock is sustained while
// the output is not back-pressured. Back-pressure on the output stalls the
// evaluation stage; the input register still takes one beat while the result
// waits. Configuration writes go straight to the registers and should
// be made only while no tick is in flight.
module button_pair_autorepeat_combo_core import bpac_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bpac_in_if.sink          i_in,
    bpac_out_if.source       o_out
);

    t_cfg              r_cfg;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_now;
    logic              r_in_left;
    logic              r_in_right;

    logic              r_out_valid;
    logic signed [1:0] r_out_step;
    logic              r_out_menu;
    logic              r_out_left;
    logic              r_out_right;

    logic              fire;
    logic              both;
    logic              menu;
    logic              left_pressed;
    logic              left_step;
    logic              right_pressed;
    logic              right_step;
    logic signed [1:0] n_step;

    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;
    assign both       = left_pressed && right_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= RST_DEBOUNCE;
            r_cfg.rpt_delay  <= RST_RPT_DELAY;
            r_cfg.rpt_start  <= RST_RPT_START;
            r_cfg.rpt_min    <= RST_RPT_MIN;
            r_cfg.rpt_shrink <= RST_RPT_SHRINK;
            r_cfg.combo_hold <= RST_COMBO_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data;
                REG_RPT_DELAY:  r_cfg.rpt_delay  <= i_cfg_data;
                REG_RPT_START:  r_cfg.rpt_start  <= i_cfg_data;
                REG_RPT_MIN:    r_cfg.rpt_min    <= i_cfg_data;
                REG_RPT_SHRINK: r_cfg.rpt_shrink <= i_cfg_data;
                REG_COMBO_HOLD: r_cfg.combo_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_now   <= i_in.now_time;
            r_in_left  <= i_in.left_level;
            r_in_right <= i_in.right_level;
        end
    end

    bpac_button u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire),
        .i_now     (r_in_now),
        .i_raw     (r_in_left),
        .i_both    (both),
        .i_cfg     (r_cfg),
        .o_pressed (left_pressed),
        .o_step    (left_step)
    );

    bpac_button u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire),
        .i_now     (r_in_now),
        .i_raw     (r_in_right),
        .i_both    (both),
        .i_cfg     (r_cfg),
        .o_pressed (right_pressed),
        .o_step    (right_step)
    );

    bpac_combo u_combo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_now   (r_in_now),
        .i_both  (both),
        .i_hold  (r_cfg.combo_hold),
        .o_menu  (menu)
    );

    always_comb begin
        if (right_step) begin
            n_step = STEP_RIGHT;
        end else if (left_step) begin
            n_step = STEP_LEFT;
        end else begin
            n_step = STEP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_step  <= n_step;
            r_out_menu  <= menu;
            r_out_left  <= left_pressed;
            r_out_right <= right_pressed;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.step_delta    = r_out_step;
    assign o_out.menu_pulse    = r_out_menu;
    assign o_out.left_pressed  = r_out_left;
    assign o_out.right_pressed = r_out_right;

endmodule

// File: tb/bpac_tick_compare.sv
// Watches both channels, predicts every tick result and compares it with the block's output.
module bpac_tick_compare import bpac_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bpac_in_if               i_tick_ch,
    bpac_out_if              i_res_ch,
    output int               o_fail_count,
    output int               o_beats_checked,
    output int               o_pending
);

    typedef struct packed {
        logic signed [1:0] delta;
        logic              menu;
        logic              left_on;
        logic              right_on;
    } tick_result_t;

    t_cfg              cfg;
    logic              stable   [2];
    logic              last_raw [2];
    logic [TIME_W-1:0] chg_t    [2];
    logic [TIME_W-1:0] fire_t   [2];
    logic [CFG_W-1:0]  ivl      [2];
    logic              fresh    [2];
    logic [TIME_W-1:0] combo_t;
    logic              combo_on;
    logic              combo_fired;

    tick_result_t due_results[$];

    function automatic tick_result_t predict_tick(input logic [TIME_W-1:0] t,
                                                  input logic [1:0] raw);
        tick_result_t r;
        logic both;
        logic [TIME_W-1:0] since;
        logic [CFG_W:0] floor_sum;
        r = '{delta: STEP_NONE, menu: 1'b0, left_on: 1'b0, right_on: 1'b0};
        for (int b = 0; b < 2; b++) begin
            if (raw[b] != last_raw[b]) begin
                last_raw[b] = raw[b];
                chg_t[b] = t;
            end
            since = t - chg_t[b];
            if (since >= {16'd0, cfg.debounce} && raw[b] != stable[b]) begin
                stable[b] = raw[b];
                if (!stable[b]) begin
                    fresh[b]  = 1'b1;
                    fire_t[b] = t + {16'd0, cfg.rpt_delay};
                    ivl[b]    = cfg.rpt_start;
                end
            end
        end
        both = !stable[0] && !stable[1];
        if (both) begin
            if (!combo_on) begin
                combo_on = 1'b1;
                combo_t  = t;
            end
            since = t - combo_t;
            if (!combo_fired && since >= {16'd0, cfg.combo_hold}) begin
                combo_fired = 1'b1;
                r.menu = 1'b1;
            end
        end else begin
            combo_on    = 1'b0;
            combo_fired = 1'b0;
        end
        for (int b = 0; b < 2; b++) begin
            if (stable[b] || both) begin
                fresh[b] = 1'b0;
            end else if (fresh[b]) begin
                fresh[b] = 1'b0;
                r.delta  = b ? STEP_RIGHT : STEP_LEFT;
            end else begin
                since = t - fire_t[b];
                if (!since[TIME_W-1]) begin
                    r.delta = b ? STEP_RIGHT : STEP_LEFT;
                    // floor test at 17 bits so min + shrink cannot wrap
                    floor_sum = {1'b0, cfg.rpt_min} + {1'b0, cfg.rpt_shrink};
                    if ({1'b0, ivl[b]} > floor_sum)
                        ivl[b] = ivl[b] - cfg.rpt_shrink;
                    else
                        ivl[b] = cfg.rpt_min;
                    fire_t[b] = t + {16'd0, ivl[b]};
                end
            end
        end
        r.left_on  = !stable[0];
        r.right_on = !stable[1];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got,
                               inout logic bad);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        tick_result_t want;
        tick_result_t got;
        logic bad;
        if (!i_rst_n) begin
            cfg = '{RST_DEBOUNCE, RST_RPT_DELAY, RST_RPT_START, RST_RPT_MIN,
                    RST_RPT_SHRINK, RST_COMBO_HOLD};
            for (int b = 0; b < 2; b++) begin
                stable[b]   = 1'b1;
                last_raw[b] = 1'b1;
                chg_t[b]    = '0;
                fire_t[b]   = '0;
                ivl[b]      = '0;
                fresh[b]    = 1'b0;
            end
            combo_t     = '0;
            combo_on    = 1'b0;
            combo_fired = 1'b0;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEBOUNCE:   cfg.debounce   = i_cfg_data;
                    REG_RPT_DELAY:  cfg.rpt_delay  = i_cfg_data;
                    REG_RPT_START:  cfg.rpt_start  = i_cfg_data;
                    REG_RPT_MIN:    cfg.rpt_min    = i_cfg_data;
                    REG_RPT_SHRINK: cfg.rpt_shrink = i_cfg_data;
                    REG_COMBO_HOLD: cfg.combo_hold = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with no tick outstanding, expected none, actual %0d",
                             $time, i_res_ch.step_delta);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = due_results.pop_front();
                    got  = '{i_res_ch.step_delta, i_res_ch.menu_pulse,
                             i_res_ch.left_pressed, i_res_ch.right_pressed};
                    bad  = 1'b0;
                    check_field("step_delta", want.delta, got.delta, bad);
                    check_field("menu_pulse", want.menu, got.menu, bad);
                    check_field("left_pressed", want.left_on, got.left_on, bad);
                    check_field("right_pressed", want.right_on, got.right_on, bad);
                    if (bad)
                        o_fail_count <= o_fail_count + 1;
                    o_beats_checked <= o_beats_checked + 1;
                end
            end
            if (i_tick_ch.valid && i_tick_ch.ready)
                due_results.push_back(predict_tick(i_tick_ch.now_time,
                                      {i_tick_ch.right_level, i_tick_ch.left_level}));
            o_pending <= due_results.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, tick stimulus, result back-pressure and verdict.
module tb_top;
    import bpac_pkg::*;

    typedef enum int {G_LEFT, G_RIGHT, G_BOTH, G_OVERLAP, G_NOISE, G_IDLE} gesture_e;
    typedef enum int {CFG_SMALL, CFG_DEFAULT, CFG_WIDE, CFG_ZERO, CFG_FULL} cfg_kind_e;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int               fail_count;
    int               beats_checked;
    int               pending;
    int               sent = 0;
    int               rx_hold = 0;
    logic             calm = 1'b0;
    logic [31:0]      now_ms = '0;

    bpac_in_if  tick_ch();
    bpac_out_if res_ch();

    button_pair_autorepeat_combo_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_ch),
        .o_out      (res_ch)
    );

    bpac_tick_compare cmp (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_tick_ch       (tick_ch),
        .i_res_ch        (res_ch),
        .o_fail_count    (fail_count),
        .o_beats_checked (beats_checked),
        .o_pending       (pending)
    );

    always #2 clk = ~clk;

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    // result side
    initial begin
        int w;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rx_hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            w = calm ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                res_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_tick(input logic [31:0] t, input logic l, input logic r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.now_time    <= t;
        tick_ch.left_level  <= l;
        tick_ch.right_level <= r;
        do @(posedge clk); while (!tick_ch.ready);
        sent++;
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        wait (beats_checked == sent);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                             input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] mn,
                             input logic [CFG_W-1:0] shr, input logic [CFG_W-1:0] hold);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_RPT_DELAY, dly);
        write_reg(REG_RPT_START, st);
        write_reg(REG_RPT_MIN, mn);
        write_reg(REG_RPT_SHRINK, shr);
        write_reg(REG_COMBO_HOLD, hold);
    endtask

    function automatic logic [CFG_W-1:0] wide_val();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic gesture(input int scale);
        gesture_e g;
        int len;
        logic l;
        logic r;
        g   = gesture_e'($urandom_range(0, 5));
        len = (g == G_NOISE || g == G_IDLE) ? $urandom_range(1, 8) : $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
            case (g)
                G_LEFT:    begin l = 1'b0; r = 1'b1; end
                G_RIGHT:   begin l = 1'b1; r = 1'b0; end
                G_BOTH:    begin l = 1'b0; r = (k < len / 4); end
                G_OVERLAP: begin l = 1'b0; r = !(k >= len / 3 && k < 2 * len / 3); end
                G_NOISE:   begin l = 1'($urandom); r = 1'($urandom); end
                default:   begin l = 1'b1; r = 1'b1; end
            endcase
            // contact bounce at the start of a gesture
            if (k < 2 && $urandom_range(0, 3) == 0) begin
                l = 1'($urandom);
                r = 1'($urandom);
            end
            if ($urandom_range(0, 49) == 0)
                now_ms = $urandom;
            else
                now_ms = now_ms + $urandom_range(0, scale);
            send_tick(now_ms, l, r);
        end
    endtask

    task automatic run_phase(input int ph);
        cfg_kind_e kind;
        int scale;
        int start;
        logic held;
        logic paused;
        drain();
        kind = (ph < 5) ? cfg_kind_e'(ph) : cfg_kind_e'($urandom_range(0, 4));
        case (kind)
            CFG_SMALL: begin
                write_all(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 12)),
                          CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 6)),
                          CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 20)));
                scale = 3;
            end
            CFG_DEFAULT: begin
                write_all(RST_DEBOUNCE, RST_RPT_DELAY, RST_RPT_START, RST_RPT_MIN,
                          RST_RPT_SHRINK, RST_COMBO_HOLD);
                scale = 40;
            end
            CFG_WIDE: begin
                write_all(wide_val(), wide_val(), wide_val(), wide_val(), wide_val(),
                          wide_val());
                scale = 30000;
            end
            CFG_ZERO: begin
                write_all('0, '0, '0, '0, '0, '0);
                scale = 2;
            end
            default: begin
                write_all('1, '1, '1, '1, '1, '1);
                scale = 40000;
            end
        endcase
        // indexes past the last register must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg(IDX_W'($urandom_range(6, 7)), CFG_W'($urandom_range(0, 65535)));
        calm   = (ph != 1) && ($urandom_range(0, 3) == 0);
        start  = sent;
        held   = 1'b0;
        paused = 1'b0;
        while (sent - start < 150) begin
            if (ph == 1 && !held && sent - start > 40) begin
                rx_hold = 60;
                held    = 1'b1;
            end
            if (ph == 2 && !paused && sent - start > 60) begin
                drain();
                paused = 1'b1;
            end
            gesture(scale);
        end
    endtask

    initial begin
        int ph;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= REG_DEBOUNCE;
        cfg_data            <= '0;
        tick_ch.valid       <= 1'b0;
        tick_ch.now_time    <= '0;
        tick_ch.left_level  <= 1'b1;
        tick_ch.right_level <= 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: debounce edge, first repeat, shrinking interval
        send_tick(32'd100, 1'b0, 1'b1);
        send_tick(32'd124, 1'b0, 1'b1);
        send_tick(32'd125, 1'b0, 1'b1);
        send_tick(32'd474, 1'b0, 1'b1);
        send_tick(32'd475, 1'b0, 1'b1);
        send_tick(32'd617, 1'b0, 1'b1);
        send_tick(32'd618, 1'b1, 1'b1);
        drain();

        // zero debounce, time wrap, combo starting at time zero, interval floor
        write_all(16'd0, 16'd2, 16'd3, 16'd1, 16'd1, 16'd2);
        send_tick(32'hFFFF_FFFE, 1'b1, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_tick(32'd0, 1'b0, 1'b0);
        send_tick(32'd1, 1'b0, 1'b0);
        send_tick(32'd2, 1'b0, 1'b0);
        send_tick(32'd3, 1'b0, 1'b0);
        send_tick(32'd4, 1'b1, 1'b0);
        send_tick(32'd5, 1'b1, 1'b0);
        send_tick(32'd6, 1'b1, 1'b0);
        send_tick(32'd7, 1'b1, 1'b0);
        send_tick(32'd8, 1'b1, 1'b1);
        send_tick(32'd9, 1'b0, 1'b1);
        now_ms = 32'd9;

        ph = 0;
        while (sent < 1550) begin
            run_phase(ph);
            ph++;
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/bpac_pkg.sv
rtl/bpac_in_if.sv
rtl/bpac_out_if.sv
rtl/bpac_button.sv
rtl/bpac_combo.sv
rtl/button_pair_autorepeat_combo_core.sv
tb/bpac_tick_compare.sv
tb/tb_top.sv
